// File: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Item payloads, controller/datapath command and status, register map.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int WINDOW_MAX_DEF = 8;
	localparam int WL_W           = 4;
	localparam int POS_W          = 3;
	localparam int FILL_W         = 4;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;

	localparam logic [WL_W-1:0] WL_RESET = 4'd5;

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       restart;
	} swm_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] median_value;
		logic [POS_W-1:0]           insert_position;
		logic [FILL_W-1:0]          fill_count;
	} swm_out_t;

	typedef struct packed {
		logic load;
		logic remove;
		logic insert;
		logic emit;
	} swm_cmd_t;

	typedef struct packed {
		logic out_busy;
	} swm_stat_t;

endpackage

// File: hw/rtl/swm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl: item sequencer
// Steps each item through load, removal, insertion and result emit.
// ----------------------------------------------------------------------------
module swm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swm_pkg::swm_stat_t stat,
	output swm_pkg::swm_cmd_t  cmd
);
	import swm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_REMOVE = 4'b0010,
		ST_INSERT = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_REMOVE;
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_d    = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/swm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_dp: window datapath
// Arrival ring, sorted cell row with compare-and-shift, output register.
// ----------------------------------------------------------------------------
module swm_dp #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  swm_pkg::swm_cmd_t          cmd,
	output swm_pkg::swm_stat_t         stat,
	input  logic                       clear,
	input  logic [swm_pkg::WL_W-1:0]   window_length,
	input  swm_pkg::swm_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output swm_pkg::swm_out_t          out_data
);
	import swm_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic signed [SAMPLE_W-1:0] sorted_q [WINDOW_MAX];
	logic signed [SAMPLE_W-1:0] ring_q   [WINDOW_MAX];
	logic signed [SAMPLE_W-1:0] key_q;
	logic [IDX_W-1:0]           head_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           pos_q;
	logic                       out_valid_q;
	swm_out_t                   out_q;

	logic [CNT_W-1:0]           len;
	logic                       full;
	logic signed [SAMPLE_W-1:0] old;
	logic [CNT_W-1:0]           at;
	logic                       found;
	logic [CNT_W-1:0]           head_nxt;
	logic [CNT_W:0]             slot;
	logic [WINDOW_MAX-1:0]      less;
	logic [CNT_W-1:0]           pos;
	logic [CNT_W-1:0]           mid;

	// effective length: 0 acts as 1, clipped to the store depth
	always_comb begin
		if (window_length == '0) begin
			len = CNT_W'(1);
		end else if (32'(window_length) > WINDOW_MAX) begin
			len = CNT_W'(WINDOW_MAX);
		end else begin
			len = CNT_W'(window_length);
		end
	end

	// removal: first sorted entry equal to the oldest sample
	assign full = (count_q >= len);
	assign old  = ring_q[head_q];

	always_comb begin
		at    = count_q - CNT_W'(1);
		found = 1'b0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (!found && (CNT_W'(i) < count_q) && (sorted_q[i] == old)) begin
				at    = CNT_W'(i);
				found = 1'b1;
			end
		end
	end

	assign head_nxt = CNT_W'(head_q) + CNT_W'(1);

	always_comb begin
		slot = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
		if (slot >= (CNT_W+1)'(len)) begin
			slot = slot - (CNT_W+1)'(len);
		end
	end

	// insertion: entries below the new key form a prefix
	always_comb begin
		pos = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			less[i] = (CNT_W'(i) < count_q) && (sorted_q[i] < key_q);
			pos     = pos + CNT_W'(less[i]);
		end
	end

	assign mid = count_q >> 1;

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				head_q  <= '0;
				count_q <= '0;
			end else if (cmd.load) begin
				if (in_data.restart) begin
					head_q  <= '0;
					count_q <= '0;
				end else begin
					if (count_q > len) begin
						count_q <= len;
					end
					if (CNT_W'(head_q) >= len) begin
						head_q <= '0;
					end
				end
			end else if (cmd.remove) begin
				if (full) begin
					count_q <= count_q - CNT_W'(1);
					head_q  <= (head_nxt >= len) ? '0 : head_nxt[IDX_W-1:0];
				end
			end else if (cmd.insert) begin
				count_q <= count_q + CNT_W'(1);
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_data.sample;
		end
		if (cmd.remove) begin
			if (full) begin
				for (int i = 0; i + 1 < WINDOW_MAX; i++) begin
					if ((CNT_W'(i) >= at) && (CNT_W'(i + 1) < count_q)) begin
						sorted_q[i] <= sorted_q[i + 1];
					end
				end
				ring_q[head_q] <= key_q;
			end else begin
				ring_q[slot[IDX_W-1:0]] <= key_q;
			end
		end
		if (cmd.insert) begin
			pos_q <= pos;
			if (pos == '0) begin
				sorted_q[0] <= key_q;
			end
			for (int i = 1; i < WINDOW_MAX; i++) begin
				if (CNT_W'(i) == pos) begin
					sorted_q[i] <= key_q;
				end else if (CNT_W'(i) > pos) begin
					sorted_q[i] <= sorted_q[i - 1];
				end
			end
		end
		if (cmd.emit) begin
			out_q.median_value    <= sorted_q[mid[IDX_W-1:0]];
			out_q.insert_position <= POS_W'(pos_q);
			out_q.fill_count      <= FILL_W'(count_q);
		end
	end

endmodule

// File: hw/rtl/sliding_window_median.sv
// Each accepted item passes the load, remove, insert and emit steps of the
// sequencer; the emit step holds while the output register is busy, and the
// next item is taken while a result waits in the output register.
// Reset (arst_n low): window empty, ring head 0, window_length = 5, no result.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the most recent samples
// Keeps the window in arrival order and in sorted order; each item gives the
// upper median, the insert position and the fill count.
// ----------------------------------------------------------------------------
module sliding_window_median #(
	parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  swm_pkg::swm_in_t              in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output swm_pkg::swm_out_t             out_data,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swm_pkg::ADDR_W-1:0]    paddr,
	input  logic [swm_pkg::DATA_W-1:0]    pwdata,
	output logic [swm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import swm_pkg::*;

	logic [WL_W-1:0] window_length_q;
	logic            cfg_wr;
	swm_cmd_t        cmd;
	swm_stat_t       stat;

	// APB: no wait states; register index in paddr[2], low bits ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WINDOW_LENGTH) begin
			prdata = DATA_W'(window_length_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WL_RESET;
		end else if (cfg_wr) begin
			window_length_q <= pwdata[WL_W-1:0];
		end
	end

	// sequencer: one item in flight, four steps
	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath; a length write also empties the window
	swm_dp #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.clear         (cfg_wr),
		.window_length (window_length_q),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sliding window median filter
// Streams signed samples through the block with random gaps on both
// channels, predicts every result in place and checks each field. Window
// lengths are rewritten over the configuration port between phases,
// including the values that fold to one and to the maximum.
// ----------------------------------------------------------------------------
module tb;
	import swm_pkg::*;

	localparam int WIN_MAX      = WINDOW_MAX_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	// idle wait after the last expected result, to cover the tail of any item
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 10;
	// pending predictions; the block never holds more than two items
	localparam int EXPECT_DEPTH = 16;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// lengths visited first in the random phases: min, max, zero, all ones,
	// one past the maximum
	localparam logic [WL_W-1:0] EDGE_LENGTHS [5] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	swm_in_t           in_data;
	logic              out_valid;
	logic              out_ready;
	swm_out_t          out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	sliding_window_median dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the filter state, advanced once per accepted item
	// ------------------------------------------------------------------
	logic signed [SAMPLE_W-1:0] win_sorted [WIN_MAX];
	logic signed [SAMPLE_W-1:0] win_ring   [WIN_MAX];
	int unsigned                win_head       = 0;
	int unsigned                win_count      = 0;
	logic [WL_W-1:0]            win_length_reg = WL_RESET;

	// expected results in order, written at acceptance, read at the output
	swm_out_t    expect_buf [EXPECT_DEPTH];
	int unsigned expect_wr = 0;
	int unsigned expect_rd = 0;

	int unsigned cycle_count = 0;
	int unsigned fail_count  = 0;
	bit          idle_on     = 1'b0;
	int unsigned rx_hold     = 0;
	int unsigned rx_gap      = 0;

	function automatic int unsigned expect_level();
		return expect_wr - expect_rd;
	endfunction

	// Next result of the filter for one item. Updates the shadow state.
	function automatic swm_out_t predict_median(input swm_in_t item);
		swm_out_t                   res;
		int unsigned                lim;
		int unsigned                at;
		int unsigned                pos;
		int unsigned                k;
		logic signed [SAMPLE_W-1:0] oldest;

		// zero folds to one, anything past the store size to the store size
		if (win_length_reg == 0)
			lim = 1;
		else if (win_length_reg > WIN_MAX)
			lim = WIN_MAX;
		else
			lim = 32'(win_length_reg);

		if (item.restart) begin
			win_head  = 0;
			win_count = 0;
		end
		if (win_count > lim)
			win_count = lim;
		if (win_head >= lim)
			win_head = 0;

		if (win_count >= lim) begin
			// full window: evict the oldest, first equal entry from the bottom;
			// the last entry is the fallback if nothing matches
			oldest = win_ring[win_head];
			at     = win_count - 1;
			for (k = win_count; k > 0; k--)
				if (win_sorted[k-1] == oldest)
					at = k - 1;
			for (k = at; k + 1 < win_count; k++)
				win_sorted[k] = win_sorted[k+1];
			win_count--;
			win_ring[win_head] = item.sample;
			win_head = (win_head + 1) % lim;
		end else begin
			win_ring[(win_head + win_count) % lim] = item.sample;
		end

		// insert ahead of any equal entries
		pos = 0;
		while (pos < win_count && win_sorted[pos] < item.sample)
			pos++;
		for (k = win_count; k > pos; k--)
			win_sorted[k] = win_sorted[k-1];
		win_sorted[pos] = item.sample;
		win_count++;

		res.median_value    = win_sorted[(win_count / 2) % WIN_MAX];
		res.insert_position = POS_W'(pos);
		res.fill_count      = FILL_W'(win_count);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int idle_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic swm_in_t make_item(input logic signed [SAMPLE_W-1:0] s, input logic rs);
		swm_in_t it;
		it.sample  = s;
		it.restart = rs;
		return it;
	endfunction

	// Random sample: wide values, a narrow band for ties, the rails, and
	// small steps from the previous sample.
	function automatic swm_in_t random_item(input logic signed [SAMPLE_W-1:0] prev);
		swm_in_t it;
		int      pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			it.sample = SAMPLE_W'($urandom());
		end else if (pick < 70) begin
			it.sample = $signed(SAMPLE_W'($urandom_range(0, 8))) - 16'sd4;
		end else if (pick < 85) begin
			case ($urandom_range(0, 3))
				0: it.sample = SAMPLE_MAX;
				1: it.sample = SAMPLE_MIN;
				2: it.sample = -16'sd1;
				default: it.sample = 16'sd0;
			endcase
		end else begin
			it.sample = prev + $signed(SAMPLE_W'($urandom_range(0, 6))) - 16'sd3;
		end
		it.restart = ($urandom_range(0, 24) == 0);
		return it;
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side: ready with random stalls, plus a long hold-off on demand
	// ------------------------------------------------------------------
	initial out_ready = 1'b0;

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else if (rx_gap > 0) begin
			out_ready <= 1'b0;
			rx_gap--;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 2) == 0)
				rx_gap = idle_gap();
		end
	end

	// Compare every taken result against the oldest prediction.
	always @(posedge clk) begin : check_result
		swm_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expect_level() == 0) begin
				log_failure($sformatf("result with nothing expected: median %0d pos %0d fill %0d",
					out_data.median_value, out_data.insert_position, out_data.fill_count));
			end else begin
				want = expect_buf[expect_rd % EXPECT_DEPTH];
				expect_rd++;
				if (out_data.median_value !== want.median_value ||
				    out_data.insert_position !== want.insert_position ||
				    out_data.fill_count !== want.fill_count)
					log_failure($sformatf({"median %0d/%0d pos %0d/%0d fill %0d/%0d",
						" (expected/actual)"},
						want.median_value, out_data.median_value,
						want.insert_position, out_data.insert_position,
						want.fill_count, out_data.fill_count));
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------

	// Offer one item and hold it until taken; predict on acceptance.
	task automatic send_sample(input swm_in_t item);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		if (expect_level() >= EXPECT_DEPTH)
			log_failure("too many items accepted without a result");
		expect_buf[expect_wr % EXPECT_DEPTH] = predict_median(item);
		expect_wr++;
	endtask

	// Stop offering and wait until every pending result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expect_level() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup + access phase; junk in the upper bits must be ignored.
	task automatic write_window_length(input logic [WL_W-1:0] len);
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({REG_WINDOW_LENGTH, 2'b00});
		pwdata  <= ($urandom() << WL_W) | DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// writing the length also empties the window
		win_length_reg = len;
		win_head       = 0;
		win_count      = 0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset length (5): rails, zero, -1 and 1, then one more to force an eviction.
	task automatic test_reset_window();
		idle_on = 1'b0;
		send_sample(make_item(SAMPLE_MIN, 1'b0));
		send_sample(make_item(SAMPLE_MAX, 1'b0));
		send_sample(make_item(16'sd0, 1'b0));
		send_sample(make_item(-16'sd1, 1'b0));
		send_sample(make_item(16'sd1, 1'b0));
		send_sample(make_item(SAMPLE_MAX, 1'b0));
	endtask

	// Ties: inserts go ahead of equals, eviction takes the first equal.
	task automatic test_equal_samples();
		write_window_length(4'd3);
		repeat (4) send_sample(make_item(16'sd4, 1'b0));
	endtask

	// Restart on a full window: fill count drops to one, median is the sample.
	task automatic test_restart();
		send_sample(make_item(16'sd9, 1'b0));
		send_sample(make_item(-16'sd7, 1'b1));
	endtask

	// Length 0 behaves as 1; length 15 as the full store. Ascending ramp
	// drives the insert position to its top value.
	task automatic test_length_limits();
		int k;
		write_window_length(4'd0);
		send_sample(make_item(16'sd30, 1'b0));
		send_sample(make_item(-16'sd30, 1'b0));
		write_window_length(4'd15);
		for (k = 0; k < 9; k++)
			send_sample(make_item($signed(SAMPLE_W'(k * 1000)), 1'b0));
	endtask

	// Random streams over a series of window lengths, one phase without idling.
	task automatic test_random_windows();
		int                         ph;
		logic [WL_W-1:0]            len;
		logic signed [SAMPLE_W-1:0] prev;
		swm_in_t                    it;
		prev = '0;
		for (ph = 0; ph < 12; ph++) begin
			if (ph < 5)
				len = EDGE_LENGTHS[ph];
			else
				len = WL_W'($urandom_range(1, 8));
			write_window_length(len);
			idle_on = (ph != 6);
			repeat (100) begin
				it = random_item(prev);
				send_sample(it);
				prev = it.sample;
			end
		end
	endtask

	// Hold the result side off for a long time while samples keep coming,
	// so the block backs up and drops in_ready.
	task automatic test_output_backpressure();
		logic signed [SAMPLE_W-1:0] prev;
		swm_in_t                    it;
		write_window_length(4'd8);
		idle_on = 1'b0;
		rx_hold = 300;
		prev    = '0;
		repeat (40) begin
			it = random_item(prev);
			send_sample(it);
			prev = it.sample;
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_equal_samples();
		test_restart();
		test_length_limits();
		test_random_windows();
		test_output_backpressure();

		drain_results();
		if (expect_level() != 0)
			log_failure($sformatf("%0d results never came out", expect_level()));

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_ctrl.sv
hw/rtl/swm_dp.sv
hw/rtl/sliding_window_median.sv
tb/tb.sv
